// ===== src/keyword_command_line_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyword command line parser
// Checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_COMMAND_LINE_PARSER_TOP_DEFINES_SVH
`define KEYWORD_COMMAND_LINE_PARSER_TOP_DEFINES_SVH
`ifndef SYNTH
`define KCLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KCLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KCLP_ASSERT(lbl, prop, msg)
`define KCLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/kclp_pkg.sv =====
// ----------------------------------------------------------------------------
// kclp_pkg
// Types, keyword table and helpers for the command line parser.
// ----------------------------------------------------------------------------
package kclp_pkg;

  localparam int FIELD_CHARS_DEF = 31;
  localparam int FIELD_SLOTS_DEF = 5;
  localparam int OUT_FIELDS      = 5;
  localparam int KEY_MAX         = 15;
  localparam int NUM_CMDS        = 31;
  localparam int KEY_BITS        = 8 * KEY_MAX;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;

  typedef enum logic [1:0] {PH_KEY, PH_GETKEY, PH_FIELDS} phase_t;
  typedef enum logic [1:0] {NS_SKIP, NS_DIGITS, NS_DONE} num_state_t;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic [7:0] ch;
  } key_ctl_t;

  typedef struct packed {
    logic       clear;
    logic       char_en;
    logic       close;
    logic [7:0] ch;
  } fld_ctl_t;

  // Keywords right-aligned, last character in the low byte
  localparam logic [KEY_BITS-1:0] KW_TEXT [NUM_CMDS] = '{
    "FAN", "SPEED", "WUHUA", "LED", "PRESET", "BRIGHT", "STREAMLIGHT",
    {"LED_", "GRADIENT"}, "LCD", "UI", "VOL", "THROTTLE", "UNIT", "TREAD", "WIFI",
    "WIFI_SCAN", "GET:FAN", "GET:WUHUA", "GET:BRIGHT", "GET:STREAMLIGHT",
    "GET:PRESET", "GET:ALL", "GET:UI", "GET:LOGO", "GET:VOL", "GET:TREAD",
    {"LOGO_", "START"}, {"LOGO_", "START_BIN"}, {"LOGO_", "DATA"},
    {"LOGO_", "END"}, {"LOGO_", "DELETE"}
  };
  localparam logic [3:0] KW_LEN [NUM_CMDS] = '{
    4'd3, 4'd5, 4'd5, 4'd3, 4'd6, 4'd6, 4'd11, 4'd12, 4'd3, 4'd2, 4'd3, 4'd8,
    4'd4, 4'd5, 4'd4, 4'd9, 4'd7, 4'd9, 4'd10, 4'd15, 4'd10, 4'd7, 4'd6, 4'd8,
    4'd7, 4'd9, 4'd10, 4'd14, 4'd9, 4'd8, 4'd11
  };

  localparam logic [4:0] CMD_NONE          = 5'd0;
  localparam logic [4:0] CMD_LED           = 5'd4;
  localparam logic [4:0] CMD_LED_RAMP      = 5'd8;
  localparam logic [4:0] CMD_NET           = 5'd15;
  localparam logic [4:0] CMD_IMG_BEGIN     = 5'd27;
  localparam logic [4:0] CMD_IMG_BEGIN_BIN = 5'd28;
  localparam logic [4:0] CMD_IMG_CHUNK     = 5'd29;

  function automatic logic [2:0] fields_kept(input logic [4:0] cmd);
    logic [2:0] k;
    case (cmd)
      CMD_NONE:          k = 3'd0;
      CMD_LED:           k = 3'd4;
      CMD_LED_RAMP:      k = 3'd5;
      CMD_NET:           k = 3'd0;
      CMD_IMG_BEGIN:     k = 3'd3;
      CMD_IMG_BEGIN_BIN: k = 3'd3;
      CMD_IMG_CHUNK:     k = 3'd2;
      default:           k = 3'd1;
    endcase
    return k;
  endfunction

endpackage

// ===== src/keyword_command_line_parser_top.sv =====
// ----------------------------------------------------------------------------
// keyword_command_line_parser_top
// Byte-stream command line parser: keyword lookup plus up to five int fields.
// ----------------------------------------------------------------------------
// One byte item per cycle enters an input register; key, field and phase
// state update from that register. An item with tlast set closes the
// line: one result item (command code plus five fields) is loaded into the
// output register and the line state clears. Throughput is one item per
// clock when not stalled. The input side stalls only while an end-of-line
// item waits behind a result that the sink has not yet taken. A zero byte
// ends the text; later bytes up to tlast are ignored. Keys over 15
// characters give command 0.
`include "keyword_command_line_parser_top_defines.svh"

module keyword_command_line_parser_top #(
  parameter int FIELD_CHARS = kclp_pkg::FIELD_CHARS_DEF,
  parameter int FIELD_SLOTS = kclp_pkg::FIELD_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // char_byte [7:0]
  input  logic         s_tlast,   // end_of_line
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata    // command [4:0], field_a [36:5], field_b [68:37],
                                  // field_c [100:69], field_d [132:101],
                                  // field_e [164:133], zero [167:165]
);

  // Input register
  logic       in_valid;
  logic       in_eol;
  logic [7:0] in_byte;

  // Line state
  kclp_pkg::phase_t phase, phase_next;
  logic             text_ended, text_ended_next;
  logic [4:0]       matched_command, matched_next;

  logic advance, step;
  kclp_pkg::key_ctl_t key_ctl;
  kclp_pkg::fld_ctl_t fld_ctl;
  logic [4:0]  lookup_cmd;
  logic        is_get;
  logic [31:0] fval [kclp_pkg::OUT_FIELDS];
  logic [4:0]  res_cmd;
  logic [2:0]  kept;

  // Items advance unless an end of line is blocked by a pending result
  assign advance  = !(in_valid && in_eol && m_tvalid && !m_tready);
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eol  <= s_tlast;
    end
  end

  // Parse control
  always_comb begin
    phase_next      = phase;
    text_ended_next = text_ended;
    matched_next    = matched_command;
    key_ctl         = '{clear: 1'b0, push: 1'b0, ch: in_byte};
    fld_ctl         = '{clear: 1'b0, char_en: 1'b0, close: 1'b0, ch: in_byte};
    if (step) begin
      if (in_eol) begin
        fld_ctl.close   = phase == kclp_pkg::PH_FIELDS;
        key_ctl.clear   = 1'b1;
        phase_next      = kclp_pkg::PH_KEY;
        text_ended_next = 1'b0;
        matched_next    = kclp_pkg::CMD_NONE;
      end else if (!text_ended) begin
        if (in_byte == 8'd0) begin
          text_ended_next = 1'b1;
        end else begin
          case (phase)
            kclp_pkg::PH_KEY: begin
              if (in_byte == kclp_pkg::CH_COLON && !is_get) begin
                matched_next = lookup_cmd;
                phase_next   = kclp_pkg::PH_FIELDS;
              end else begin
                key_ctl.push = 1'b1;
                if (in_byte == kclp_pkg::CH_COLON) phase_next = kclp_pkg::PH_GETKEY;
              end
            end
            kclp_pkg::PH_GETKEY: begin
              if (in_byte == kclp_pkg::CH_COLON) begin
                matched_next = lookup_cmd;
                phase_next   = kclp_pkg::PH_FIELDS;
              end else begin
                key_ctl.push = 1'b1;
              end
            end
            default: begin
              if (in_byte == kclp_pkg::CH_COLON) fld_ctl.close   = 1'b1;
              else                               fld_ctl.char_en = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // Field store clears the cycle after its last use on the line
  logic fld_clear;
  always_ff @(posedge clk) begin
    if (rst) fld_clear <= 1'b0;
    else     fld_clear <= step && in_eol;
  end

  kclp_pkg::fld_ctl_t fld_ctl_q;
  always_comb begin
    fld_ctl_q       = fld_ctl;
    fld_ctl_q.clear = fld_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= kclp_pkg::PH_KEY;
      text_ended      <= 1'b0;
      matched_command <= kclp_pkg::CMD_NONE;
    end else begin
      phase           <= phase_next;
      text_ended      <= text_ended_next;
      matched_command <= matched_next;
    end
  end

  kclp_key u_key (
    .clk    (clk),
    .rst    (rst),
    .ctl    (key_ctl),
    .cmd    (lookup_cmd),
    .is_get (is_get)
  );

  kclp_field #(
    .FIELD_CHARS (FIELD_CHARS),
    .FIELD_SLOTS (FIELD_SLOTS)
  ) u_field (
    .clk (clk),
    .rst (rst),
    .ctl (fld_ctl_q),
    .val (fval)
  );

  // Result assembly
  always_comb begin
    case (phase)
      kclp_pkg::PH_FIELDS: res_cmd = matched_command;
      kclp_pkg::PH_GETKEY: res_cmd = lookup_cmd;
      default:             res_cmd = kclp_pkg::CMD_NONE;
    endcase
    kept = kclp_pkg::fields_kept(res_cmd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && in_eol) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_eol) begin
      m_tdata[4:0]     <= res_cmd;
      m_tdata[167:165] <= '0;
      for (int j = 0; j < kclp_pkg::OUT_FIELDS; j++)
        m_tdata[5 + 32*j +: 32] <= (3'(j) < kept) ? fval[j] : 32'd0;
    end
  end

  `KCLP_ASSERT(a_eol_held, in_valid && in_eol && m_tvalid && !m_tready |=> in_valid, "stalled end of line lost")
  `KCLP_ASSERT(a_result_src, $rose(m_tvalid) |-> $past(in_valid && in_eol), "result without end of line")
  `KCLP_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[167:165] == 3'd0, "tdata padding not zero")
  `KCLP_ASSERT(a_unknown_zero, m_tvalid && m_tdata[4:0] == kclp_pkg::CMD_NONE |-> m_tdata[164:5] == '0, "unknown command with fields")
  `KCLP_ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid && !in_valid, "not idle after reset")

endmodule

// ===== src/kclp_key.sv =====
// ----------------------------------------------------------------------------
// kclp_key
// Key shift register and keyword lookup.
// ----------------------------------------------------------------------------
module kclp_key (
  input  logic              clk,
  input  logic              rst,
  input  kclp_pkg::key_ctl_t ctl,
  output logic [4:0]        cmd,
  output logic              is_get
);

  logic [kclp_pkg::KEY_BITS-1:0] key_chars;
  logic [3:0]                    key_length;
  logic                          key_too_long;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      key_chars    <= '0;
      key_length   <= '0;
      key_too_long <= 1'b0;
    end else if (ctl.push) begin
      if (key_length < 4'(kclp_pkg::KEY_MAX)) begin
        key_chars  <= {key_chars[kclp_pkg::KEY_BITS-9:0], ctl.ch};
        key_length <= key_length + 4'd1;
      end else begin
        key_too_long <= 1'b1;
      end
    end
  end

  always_comb begin
    cmd = kclp_pkg::CMD_NONE;
    for (int i = kclp_pkg::NUM_CMDS - 1; i >= 0; i--) begin
      if (key_chars == kclp_pkg::KW_TEXT[i] && key_length == kclp_pkg::KW_LEN[i])
        cmd = 5'(i + 1);
    end
    if (key_too_long)
      cmd = kclp_pkg::CMD_NONE;
  end

  assign is_get = !key_too_long && key_length == 4'd3 && key_chars[23:0] == "GET";

endmodule

// ===== src/kclp_field.sv =====
// ----------------------------------------------------------------------------
// kclp_field
// Per-field atoi with 32-bit saturation and the field value store.
// ----------------------------------------------------------------------------
module kclp_field #(
  parameter int FIELD_CHARS = kclp_pkg::FIELD_CHARS_DEF,
  parameter int FIELD_SLOTS = kclp_pkg::FIELD_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  kclp_pkg::fld_ctl_t ctl,
  output logic [31:0]        val [kclp_pkg::OUT_FIELDS]
);

  localparam int IW = $clog2(FIELD_SLOTS + 1);
  localparam int CW = $clog2(FIELD_CHARS + 1);

  logic [IW-1:0]          field_index;
  logic [CW-1:0]          field_char_count;
  kclp_pkg::num_state_t   number_state;
  logic                   negative_sign;
  logic [31:0]            mag;
  logic [31:0]            field_values [FIELD_SLOTS];

  logic        slot_ok, is_digit, is_ws, is_sign, char_ok;
  logic [35:0] mag_x10;
  logic [31:0] mag_next, sat;

  assign slot_ok  = field_index < IW'(FIELD_SLOTS);
  assign is_digit = ctl.ch >= kclp_pkg::CH_ZERO && ctl.ch <= kclp_pkg::CH_NINE;
  assign is_ws    = ctl.ch == kclp_pkg::CH_SPACE ||
                    (ctl.ch >= kclp_pkg::CH_TAB && ctl.ch <= kclp_pkg::CH_CR);
  assign is_sign  = ctl.ch == kclp_pkg::CH_PLUS || ctl.ch == kclp_pkg::CH_MINUS;
  assign char_ok  = ctl.char_en && slot_ok && field_char_count < CW'(FIELD_CHARS);

  assign mag_x10  = {mag, 3'b000} + {2'b00, mag, 1'b0} + 36'(ctl.ch[3:0]);
  assign mag_next = (mag_x10 > 36'(kclp_pkg::MAG_CAP)) ? kclp_pkg::MAG_CAP
                                                        : mag_x10[31:0];
  assign sat = negative_sign ? (32'd0 - mag)
             : ((mag > kclp_pkg::POS_MAX) ? kclp_pkg::POS_MAX : mag);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      field_index      <= '0;
      field_char_count <= '0;
      number_state     <= kclp_pkg::NS_SKIP;
      negative_sign    <= 1'b0;
      mag              <= '0;
      for (int j = 0; j < FIELD_SLOTS; j++) field_values[j] <= '0;
    end else if (ctl.close) begin
      if (slot_ok) begin
        for (int j = 0; j < FIELD_SLOTS; j++)
          if (field_index == IW'(j)) field_values[j] <= sat;
        field_index      <= field_index + IW'(1);
        field_char_count <= '0;
        number_state     <= kclp_pkg::NS_SKIP;
        negative_sign    <= 1'b0;
        mag              <= '0;
      end
    end else if (char_ok) begin
      field_char_count <= field_char_count + CW'(1);
      case (number_state)
        kclp_pkg::NS_SKIP: begin
          if (is_sign) begin
            negative_sign <= ctl.ch == kclp_pkg::CH_MINUS;
            number_state  <= kclp_pkg::NS_DIGITS;
          end else if (is_digit) begin
            mag          <= mag_next;
            number_state <= kclp_pkg::NS_DIGITS;
          end else if (!is_ws) begin
            number_state <= kclp_pkg::NS_DONE;
          end
        end
        kclp_pkg::NS_DIGITS: begin
          if (is_digit) mag <= mag_next;
          else          number_state <= kclp_pkg::NS_DONE;
        end
        default: ;
      endcase
    end
  end

  // Stored values, with a field being closed this cycle shown in place
  always_comb begin
    for (int j = 0; j < kclp_pkg::OUT_FIELDS; j++) begin
      val[j] = field_values[j];
      if (ctl.close && slot_ok && field_index == IW'(j)) val[j] = sat;
    end
  end

endmodule

// ===== test/keyword_command_line_parser_checker.sv =====
// ----------------------------------------------------------------------------
// keyword_command_line_parser_checker
// Watches both stream channels, predicts each command line result and
// compares it field by field with what the parser sends.
// ----------------------------------------------------------------------------
module keyword_command_line_parser_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [167:0] m_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FCHARS = kclp_pkg::FIELD_CHARS_DEF;
  localparam int FSLOTS = kclp_pkg::FIELD_SLOTS_DEF;

  string cmd_names [kclp_pkg::NUM_CMDS] = '{
    "FAN", "SPEED", "WUHUA", "LED", "PRESET", "BRIGHT", "STREAMLIGHT",
    {"LED_", "GRADIENT"}, "LCD", "UI", "VOL", "THROTTLE", "UNIT", "TREAD", "WIFI",
    "WIFI_SCAN", "GET:FAN", "GET:WUHUA", "GET:BRIGHT", "GET:STREAMLIGHT",
    "GET:PRESET", "GET:ALL", "GET:UI", "GET:LOGO", "GET:VOL", "GET:TREAD",
    {"LOGO_", "START"}, {"LOGO_", "START_BIN"}, {"LOGO_", "DATA"},
    {"LOGO_", "END"}, {"LOGO_", "DELETE"}
  };

  logic [167:0] line_results [$];

  // predictor line state
  logic [7:0]           kbuf [16];
  int                   klen;
  bit                   klong;
  kclp_pkg::phase_t     phase;
  bit                   ended;
  int                   fidx;
  int                   fcnt;
  kclp_pkg::num_state_t nstate;
  bit                   neg;
  logic [31:0]          fvals [FSLOTS];
  logic [4:0]           cmd_hit;
  longint unsigned      mag;

  function automatic logic [4:0] key_lookup();
    string s;
    bit eq;
    if (klong) return kclp_pkg::CMD_NONE;
    for (int i = 0; i < kclp_pkg::NUM_CMDS; i++) begin
      s = cmd_names[i];
      if (s.len() != klen) continue;
      eq = 1;
      for (int j = 0; j < klen; j++)
        if (s[j] != kbuf[j]) eq = 0;
      if (eq) return 5'(i + 1);
    end
    return kclp_pkg::CMD_NONE;
  endfunction

  function automatic int kept_count(logic [4:0] c);
    case (c)
      kclp_pkg::CMD_NONE, kclp_pkg::CMD_NET: return 0;
      kclp_pkg::CMD_LED: return 4;
      kclp_pkg::CMD_LED_RAMP: return 5;
      kclp_pkg::CMD_IMG_BEGIN, kclp_pkg::CMD_IMG_BEGIN_BIN: return 3;
      kclp_pkg::CMD_IMG_CHUNK: return 2;
      default: return 1;
    endcase
  endfunction

  task automatic field_begin();
    fcnt = 0; nstate = kclp_pkg::NS_SKIP; neg = 0; mag = 0;
  endtask

  task automatic line_clear();
    klen = 0; klong = 0; phase = kclp_pkg::PH_KEY; ended = 0; fidx = 0;
    for (int i = 0; i < FSLOTS; i++) fvals[i] = '0;
    cmd_hit = kclp_pkg::CMD_NONE;
    field_begin();
  endtask

  task automatic key_add(logic [7:0] c);
    if (klen < kclp_pkg::KEY_MAX) begin
      kbuf[klen] = c; klen++;
    end else klong = 1;
  endtask

  task automatic field_close();
    longint unsigned m;
    if (fidx >= FSLOTS) return;
    if (neg) begin
      m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      fvals[fidx] = 32'(0 - m);
    end else begin
      fvals[fidx] = (mag > 64'h7FFF_FFFF) ? kclp_pkg::POS_MAX : 32'(mag);
    end
    fidx++;
    field_begin();
  endtask

  task automatic field_add(logic [7:0] c);
    if (fidx >= FSLOTS || fcnt >= FCHARS) return;
    fcnt++;
    if (nstate == kclp_pkg::NS_SKIP) begin
      if (c == kclp_pkg::CH_SPACE || (c >= kclp_pkg::CH_TAB && c <= kclp_pkg::CH_CR)) return;
      if (c == kclp_pkg::CH_PLUS || c == kclp_pkg::CH_MINUS) begin
        neg = (c == kclp_pkg::CH_MINUS); nstate = kclp_pkg::NS_DIGITS; return;
      end
      nstate = kclp_pkg::NS_DIGITS;
    end
    if (nstate == kclp_pkg::NS_DIGITS) begin
      if (c >= kclp_pkg::CH_ZERO && c <= kclp_pkg::CH_NINE) begin
        mag = mag * 10 + (c - kclp_pkg::CH_ZERO);
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      end else nstate = kclp_pkg::NS_DONE;
    end
  endtask

  task automatic byte_predict(logic [7:0] c, logic eol);
    logic [167:0] r;
    int kept;
    if (eol) begin
      if (phase == kclp_pkg::PH_FIELDS) field_close();
      else if (phase == kclp_pkg::PH_GETKEY) cmd_hit = key_lookup();
      else cmd_hit = kclp_pkg::CMD_NONE;
      kept = kept_count(cmd_hit);
      r = '0;
      r[4:0] = cmd_hit;
      for (int j = 0; j < kclp_pkg::OUT_FIELDS; j++)
        if (j < kept) r[5 + 32*j +: 32] = fvals[j];
      line_results.push_back(r);
      line_clear();
      return;
    end
    if (ended) return;
    if (c == 8'h00) begin
      ended = 1; return;
    end
    case (phase)
      kclp_pkg::PH_KEY: begin
        if (c == kclp_pkg::CH_COLON) begin
          // a bare GET key keeps going to the next colon
          if (!klong && klen == 3 && kbuf[0] == "G" && kbuf[1] == "E" && kbuf[2] == "T") begin
            key_add(c); phase = kclp_pkg::PH_GETKEY;
          end else begin
            cmd_hit = key_lookup(); phase = kclp_pkg::PH_FIELDS; field_begin();
          end
        end else key_add(c);
      end
      kclp_pkg::PH_GETKEY: begin
        if (c == kclp_pkg::CH_COLON) begin
          cmd_hit = key_lookup(); phase = kclp_pkg::PH_FIELDS; field_begin();
        end else key_add(c);
      end
      default: begin
        if (c == kclp_pkg::CH_COLON) field_close();
        else field_add(c);
      end
    endcase
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    line_clear();
  end

  always @(posedge clk) begin
    logic [167:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) byte_predict(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (line_results.size() == 0) begin
          $error("unexpected result item %h", m_tdata);
          fail_count++;
        end else begin
          want = line_results.pop_front();
          if (want[4:0] !== m_tdata[4:0]) begin
            $error("command: expected %0d actual %0d", want[4:0], m_tdata[4:0]);
            fail_count++;
          end
          for (int j = 0; j < kclp_pkg::OUT_FIELDS; j++)
            if (want[5 + 32*j +: 32] !== m_tdata[5 + 32*j +: 32]) begin
              $error("field_%s: expected %0d actual %0d", string'(8'("a" + j)),
                     $signed(want[5 + 32*j +: 32]), $signed(m_tdata[5 + 32*j +: 32]));
              fail_count++;
            end
          if (m_tdata[167:165] !== 3'b000) begin
            $error("pad: expected 0 actual %0d", m_tdata[167:165]);
            fail_count++;
          end
        end
      end
    end
    pending = line_results.size();
  end

endmodule

// ===== test/keyword_command_line_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// keyword_command_line_parser_top_tb
// Drives command lines byte by byte with random gaps and sink stalls; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module keyword_command_line_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;   // char_byte [7:0]
  logic         s_tlast;   // end_of_line
  logic         m_tvalid;
  logic         m_tready;
  logic [167:0] m_tdata;   // command [4:0], field_a..field_e, zero pad on top

  int fail_count;
  int pending;
  int idle_cycles;
  int sent;

  keyword_command_line_parser_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  keyword_command_line_parser_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  string keys [31] = '{
    "FAN", "SPEED", "WUHUA", "LED", "PRESET", "BRIGHT", "STREAMLIGHT",
    {"LED_", "GRADIENT"}, "LCD", "UI", "VOL", "THROTTLE", "UNIT", "TREAD", "WIFI",
    "WIFI_SCAN", "GET:FAN", "GET:WUHUA", "GET:BRIGHT", "GET:STREAMLIGHT",
    "GET:PRESET", "GET:ALL", "GET:UI", "GET:LOGO", "GET:VOL", "GET:TREAD",
    {"LOGO_", "START"}, {"LOGO_", "START_BIN"}, {"LOGO_", "DATA"},
    {"LOGO_", "END"}, {"LOGO_", "DELETE"}
  };

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("keyword_command_line_parser_top test failed");
      $finish;
    end
  end

  // sink: random stall before each result, with calm stretches
  initial begin
    int w;
    m_tready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
    end
  end

  // one byte item; gap drawn per item, valid held across back-to-back items
  task automatic put_item(logic [7:0] c, logic eol, bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= c;
    s_tlast  <= eol;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic put_line(string txt, bit calm);
    for (int i = 0; i < txt.len(); i++) put_item(txt[i], 1'b0, calm);
    put_item(8'($urandom), 1'b1, calm);
  endtask

  function automatic string rand_number();
    string s;
    int n;
    case ($urandom_range(0, 7))
      0: s = "2147483647";
      1: s = "-2147483648";
      2: s = "99999999999";
      3: s = "-99999999999";
      4: s = $sformatf("%0d", $signed($urandom));
      default: s = $sformatf("%0d", $urandom_range(0, 1000));
    endcase
    n = $urandom_range(0, 5);
    if (n == 1) s = {" \t", s};
    if (n == 2) s = {"+", s};
    if (n == 3) s = {s, "x7"};
    return s;
  endfunction

  function automatic string rand_line();
    string s;
    string f;
    int nf;
    if ($urandom_range(0, 7) == 0) begin
      // noise: random bytes, with colons sprinkled in
      s = "";
      nf = $urandom_range(0, 40);
      for (int i = 0; i < nf; i++)
        s = {s, ($urandom_range(0, 4) == 0) ? ":" : string'(8'($urandom_range(1, 255)))};
      return s;
    end
    s = keys[$urandom_range(0, 30)];
    if ($urandom_range(0, 9) == 0) s = {s, "X"};
    nf = $urandom_range(0, 7);
    for (int i = 0; i < nf; i++) begin
      f = rand_number();
      if ($urandom_range(0, 9) == 0) f = {f, "000000000000000000000000000000"};
      s = {s, ":", f};
    end
    return s;
  endfunction

  initial begin
    string txt;
    bit calm;
    rst = 1;
    s_tvalid = 0;
    s_tdata = 0;
    s_tlast = 0;
    sent = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed lines
    put_line("LED:255:-1:2147483648:-2147483649:9", 1'b0);
    put_line({"LED_", "GRADIENT:1:2:3:4:5:6"}, 1'b0);
    put_line("GET:STREAMLIGHT", 1'b0);
    put_line("GET:FAN:12", 1'b0);
    put_line("GET:", 1'b0);
    put_line("NOCOLON", 1'b0);
    put_line("", 1'b0);
    put_line("ABCDEFGHIJKLMNOPQ:5", 1'b0);
    put_line({"LOGO_", "DATA:  +42abc:-7"}, 1'b1);
    put_line("FAN:1234567890123456789012345678901234", 1'b0);
    put_line({"LOGO_", "START_BIN:::"}, 1'b0);
    put_item("F", 1'b0, 1'b0); put_item("A", 1'b0, 1'b0); put_item("N", 1'b0, 1'b0);
    put_item(":", 1'b0, 1'b0); put_item("5", 1'b0, 1'b0); put_item(8'h00, 1'b0, 1'b0);
    put_item("9", 1'b0, 1'b0); put_item(8'hFF, 1'b1, 1'b0);
    put_line("WIFI:12", 1'b0);

    // hold off until all results are in
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    while (sent < 1150) begin
      txt = rand_line();
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 15) == 0) begin
        txt = {txt, string'(8'h00), "LED:7"};
      end
      put_line(txt, calm);
    end
    s_tvalid <= 0;
    s_tlast <= 0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyword_command_line_parser_top test passed");
    end else begin
      $display("keyword_command_line_parser_top test failed");
    end
    $finish;
  end

endmodule
